### src/format_spec_parser_assert.svh
`ifndef FORMAT_SPEC_PARSER_ASSERT_SVH
`define FORMAT_SPEC_PARSER_ASSERT_SVH

// Same-cycle implication, not checked while reset is high.
`define FSP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("format_spec_parser check failed");

// Next-cycle implication, not checked while reset is high.
`define FSP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("format_spec_parser check failed");

// Next-cycle implication that is also checked across reset.
`define FSP_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("format_spec_parser check failed");

`endif

### src/fsp_pkg.sv
package fsp_pkg;

   localparam int CH_W       = 8;
   localparam int VAL_W      = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USER_W = 1;

   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOT    = 8'h2E;

   localparam logic [3:0] SPEC_C  = 4'd0;
   localparam logic [3:0] SPEC_S  = 4'd1;
   localparam logic [3:0] SPEC_P  = 4'd2;
   localparam logic [3:0] SPEC_D  = 4'd3;
   localparam logic [3:0] SPEC_I  = 4'd4;
   localparam logic [3:0] SPEC_U  = 4'd5;
   localparam logic [3:0] SPEC_X  = 4'd6;
   localparam logic [3:0] SPEC_UX = 4'd7;
   localparam logic [3:0] SPEC_B  = 4'd8;
   localparam logic [3:0] SPEC_N  = 4'd9;
   localparam logic [3:0] SPEC_A  = 4'd10;
   localparam logic [3:0] SPEC_M  = 4'd11;

   localparam logic [31:0] DIGIT_MAX = 32'h7FFF_FFFF;
   localparam logic [7:0]  COUNT_MAX = 8'hFF;

   typedef enum logic [2:0] {
      PH_FLAGS,
      PH_WDIG,
      PH_AFTERW,
      PH_PSTART,
      PH_PDIG,
      PH_SPEC
   } phase_type;

   typedef struct packed {
      logic [7:0]         ch;
      logic signed [31:0] star_value;
   } item_type;

   typedef struct packed {
      logic               spec_found;
      logic [3:0]         spec_index;
      logic [5:0]         flag_bits;
      logic signed [31:0] width_value;
      logic               width_given;
      logic signed [31:0] precision_value;
      logic               precision_given;
      logic [7:0]         chars_used;
   } result_type;

   // One-hot flag bit for a flag character, zero for anything else.
   function automatic logic [5:0] flag_match(input logic [7:0] ch);
      logic [5:0] bits;
      case (ch)
         CH_DASH:   bits = 6'b000001;
         CH_PLUS:   bits = 6'b000010;
         CH_SPACE:  bits = 6'b000100;
         CH_HASH:   bits = 6'b001000;
         CH_ZERO:   bits = 6'b010000;
         CH_BSLASH: bits = 6'b100000;
         default:   bits = 6'b000000;
      endcase
      return bits;
   endfunction

   // {found, index} for the specifier letters.
   function automatic logic [4:0] spec_match(input logic [7:0] ch);
      logic [4:0] res;
      case (ch)
         8'h63:   res = {1'b1, SPEC_C};
         8'h73:   res = {1'b1, SPEC_S};
         8'h70:   res = {1'b1, SPEC_P};
         8'h64:   res = {1'b1, SPEC_D};
         8'h69:   res = {1'b1, SPEC_I};
         8'h75:   res = {1'b1, SPEC_U};
         8'h78:   res = {1'b1, SPEC_X};
         8'h58:   res = {1'b1, SPEC_UX};
         8'h62:   res = {1'b1, SPEC_B};
         8'h6E:   res = {1'b1, SPEC_N};
         8'h61:   res = {1'b1, SPEC_A};
         8'h6D:   res = {1'b1, SPEC_M};
         default: res = {1'b0, SPEC_C};
      endcase
      return res;
   endfunction

   // acc * 10 + d, saturating at the largest positive 32-bit value.
   function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [3:0] d);
      logic [35:0] v;
      v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, d};
      if (v > {4'd0, DIGIT_MAX}) begin
         return DIGIT_MAX;
      end
      return v[31:0];
   endfunction

endpackage

### src/format_spec_parser.sv
// A request that ends a spec is held in the input register, and its result then in the result
// register that drives rsp_tvalid. Throughput: one request per cycle, as the parser state and
// the width and precision accumulators take one update per character.
// A request that ends a spec waits only while the result register is full and stalled.
// Reset is synchronous and active high; it returns the parser to the flags phase and
// empties both the input register and the result register.
module format_spec_parser (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata, from bit 0 up: ch [7:0], star_value [39:8]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fsp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata, from bit 0 up: spec_index [3:0], flag_bits [9:4], width_value [41:10],
   // width_given [42], precision_value [74:43], precision_given [75],
   // chars_used [83:76], zero fill [87:84]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fsp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser, from bit 0 up: spec_found [0]
   output logic [fsp_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import fsp_pkg::*;

   item_type   item;
   result_type result;
   logic       item_valid;
   logic       emit;
   logic       slot_free;
   logic       fire;

   // The character in the input register is consumed when it either makes no
   // result or the result register can take the result it makes. Characters
   // that only update the accumulators never wait on the result side.
   assign fire = item_valid && (!emit || slot_free);

   fsp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   // Phase machine and accumulators; reports whether this character ends the
   // spec and what the result of that spec is.
   fsp_parse_core u_core (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .fire   (fire),
      .emit   (emit),
      .result (result)
   );

   fsp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (fire && emit),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### src/fsp_in_stage.sv
module fsp_in_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fsp_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            take,
   output logic                            item_valid,
   output fsp_pkg::item_type               item
);
   import fsp_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.ch         <= req_tdata[7:0];
         item_ff.star_value <= $signed(req_tdata[39:8]);
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### src/fsp_parse_core.sv
module fsp_parse_core (
   input  logic                 clock,
   input  logic                 reset,
   input  fsp_pkg::item_type    item,
   input  logic                 fire,
   output logic                 emit,
   output fsp_pkg::result_type  result
);
   import fsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [5:0]  flag_ff, flag_in;
   logic [31:0] width_ff, width_in;
   logic        wseen_ff, wseen_in;
   logic [31:0] prec_ff, prec_in;
   logic        pseen_ff, pseen_in;
   logic [7:0]  count_ff, count_in;

   logic [5:0]  flag_hit;
   logic [4:0]  spec_hit;
   logic        is_star, is_dot, is_digit;
   logic [3:0]  digit;
   logic        bump;
   logic        count_sat;

   assign flag_hit  = flag_match(item.ch);
   assign spec_hit  = spec_match(item.ch);
   assign is_star   = (item.ch == CH_STAR);
   assign is_dot    = (item.ch == CH_DOT);
   assign is_digit  = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
   assign digit     = item.ch[3:0];
   assign count_sat = (count_ff == COUNT_MAX);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_FLAGS: begin
            if (flag_hit != 6'd0) begin
               phase_in = PH_FLAGS;
            end else if (is_star) begin
               phase_in = PH_AFTERW;
            end else if (is_digit) begin
               phase_in = PH_WDIG;
            end else if (is_dot) begin
               phase_in = PH_PSTART;
            end else begin
               phase_in = PH_FLAGS;
            end
         end
         PH_WDIG: begin
            if (is_digit) begin
               phase_in = PH_WDIG;
            end else if (is_dot) begin
               phase_in = PH_PSTART;
            end else begin
               phase_in = PH_FLAGS;
            end
         end
         PH_AFTERW: begin
            phase_in = is_dot ? PH_PSTART : PH_FLAGS;
         end
         PH_PSTART: begin
            if (is_star) begin
               phase_in = PH_SPEC;
            end else if (is_digit) begin
               phase_in = PH_PDIG;
            end else begin
               phase_in = PH_FLAGS;
            end
         end
         PH_PDIG: begin
            phase_in = is_digit ? PH_PDIG : PH_FLAGS;
         end
         default: begin
            phase_in = PH_FLAGS;
         end
      endcase
   end

   // Accumulator updates and the end-of-spec decision.
   always_comb begin
      flag_in  = flag_ff;
      width_in = width_ff;
      wseen_in = wseen_ff;
      prec_in  = prec_ff;
      pseen_in = pseen_ff;
      bump     = 1'b0;
      emit     = 1'b0;
      case (phase_ff)
         PH_FLAGS: begin
            if (flag_hit != 6'd0) begin
               flag_in = flag_ff | flag_hit;
               bump    = 1'b1;
            end else if (is_star) begin
               width_in = item.star_value;
               wseen_in = 1'b1;
               bump     = 1'b1;
            end else if (is_digit) begin
               width_in = {28'd0, digit};
               wseen_in = 1'b1;
               bump     = 1'b1;
            end else if (is_dot) begin
               pseen_in = 1'b1;
               prec_in  = 32'd0;
               bump     = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         PH_WDIG: begin
            if (is_digit) begin
               width_in = add_digit(width_ff, digit);
               bump     = 1'b1;
            end else if (is_dot) begin
               pseen_in = 1'b1;
               prec_in  = 32'd0;
               bump     = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         PH_AFTERW: begin
            if (is_dot) begin
               pseen_in = 1'b1;
               prec_in  = 32'd0;
               bump     = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         PH_PSTART: begin
            if (is_star) begin
               prec_in = item.star_value;
               bump    = 1'b1;
            end else if (is_digit) begin
               prec_in = {28'd0, digit};
               bump    = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         PH_PDIG: begin
            if (is_digit) begin
               prec_in = add_digit(prec_ff, digit);
               bump    = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         default: begin
            emit = 1'b1;
         end
      endcase

      count_in = (bump && !count_sat) ? count_ff + 8'd1 : count_ff;

      // A finished spec starts the next one from a clean slate.
      if (emit) begin
         flag_in  = 6'd0;
         width_in = 32'd0;
         wseen_in = 1'b0;
         prec_in  = 32'd0;
         pseen_in = 1'b0;
         count_in = 8'd0;
      end
   end

   // The ending letter counts only when it is a real specifier.
   always_comb begin
      result.spec_found      = spec_hit[4];
      result.spec_index      = spec_hit[3:0];
      result.flag_bits       = flag_ff;
      result.width_value     = $signed(width_ff);
      result.width_given     = wseen_ff;
      result.precision_value = $signed(prec_ff);
      result.precision_given = pseen_ff;
      result.chars_used      = (spec_hit[4] && !count_sat) ? count_ff + 8'd1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAGS;
         flag_ff  <= 6'd0;
         width_ff <= 32'd0;
         wseen_ff <= 1'b0;
         prec_ff  <= 32'd0;
         pseen_ff <= 1'b0;
         count_ff <= 8'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         flag_ff  <= flag_in;
         width_ff <= width_in;
         wseen_ff <= wseen_in;
         prec_ff  <= prec_in;
         pseen_ff <= pseen_in;
         count_ff <= count_in;
      end
   end

endmodule

### src/fsp_out_stage.sv
module fsp_out_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  fsp_pkg::result_type             result,
   output logic                            slot_free,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fsp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [fsp_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import fsp_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign slot_free = !valid_ff || rsp_tready;
   assign valid_in  = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.spec_found;
   assign rsp_tdata  = {4'd0,
                        res_ff.chars_used,
                        res_ff.precision_given,
                        res_ff.precision_value,
                        res_ff.width_given,
                        res_ff.width_value,
                        res_ff.flag_bits,
                        res_ff.spec_index};

endmodule

### src/fsp_checker.sv
`include "format_spec_parser_assert.svh"

module fsp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [fsp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [fsp_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import fsp_pkg::*;

   // A stalled result stays offered.
   `FSP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // Nothing is offered right after reset.
   `FSP_ASSERT_ALWAYS(a_rsp_reset, reset, !rsp_tvalid)
   // A spec that failed reports index zero.
   `FSP_ASSERT_NOW(a_bad_index, rsp_tvalid && !rsp_tuser[0], rsp_tdata[3:0] == SPEC_C)
   // A found spec counts its letter and names one of the twelve letters.
   `FSP_ASSERT_NOW(a_found_fields, rsp_tvalid && rsp_tuser[0], rsp_tdata[83:76] != 8'd0 && rsp_tdata[3:0] <= SPEC_M)

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the format spec parser. Each request carries one character of
// a print format (the part after the percent sign) and the argument value that
// a '*' would take. A model of the parser inside this module follows every
// accepted request and queues the result that a finished spec must produce.
// A checker pops that queue for every result that the block hands over and
// compares it field by field. Both the request side and the result side idle
// in random bursts, except near the end of the run.
module tb_top;
   import fsp_pkg::*;

   // Characters that the random specs are built from.
   localparam string FLAG_SET = "-+ #0\\";
   localparam string LETTER_SET = "cspdiuxXbnam";

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // Model of the parser: the phase and everything gathered for the open spec.
   phase_type   spec_phase;
   logic [5:0]  spec_flags;
   logic [31:0] spec_width;
   logic        spec_width_seen;
   logic [31:0] spec_prec;
   logic        spec_prec_seen;
   logic [7:0]  spec_count;

   // Results that finished specs still owe, oldest first.
   result_type pending_specs[$];

   int  error_count = 0;
   int  sent_count = 0;
   bit  idling_on = 1'b1;
   int  rsp_stall_left = 0;

   always #5 clock = ~clock;

   format_spec_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ---------------------------------------------------------------------
   // Parser model
   // ---------------------------------------------------------------------

   function automatic void clear_spec();
      spec_phase      = PH_FLAGS;
      spec_flags      = '0;
      spec_width      = '0;
      spec_width_seen = 1'b0;
      spec_prec       = '0;
      spec_prec_seen  = 1'b0;
      spec_count      = '0;
   endfunction

   // The character count sticks at its top value on long specs.
   function automatic void count_char();
      if (spec_count != COUNT_MAX) begin
         spec_count = spec_count + 8'd1;
      end
   endfunction

   function automatic bit is_digit(input logic [7:0] ch);
      return ch >= CH_ZERO && ch <= CH_NINE;
   endfunction

   // Shifts one decimal digit into a value, saturating at the largest
   // positive 32-bit number.
   function automatic logic [31:0] append_digit(input logic [31:0] acc, input logic [7:0] ch);
      logic [63:0] grown;
      grown = 64'(acc) * 64'd10 + 64'(ch - CH_ZERO);
      return (grown > 64'(DIGIT_MAX)) ? DIGIT_MAX : grown[31:0];
   endfunction

   // Closes the spec with ch as its last character. A specifier letter makes
   // a valid result and is counted; anything else makes an invalid result and
   // is dropped without being counted or parsed again.
   function automatic void end_spec(input logic [7:0] ch);
      result_type res;
      res = '0;
      res.spec_found = 1'b1;
      case (ch)
         "c":     res.spec_index = SPEC_C;
         "s":     res.spec_index = SPEC_S;
         "p":     res.spec_index = SPEC_P;
         "d":     res.spec_index = SPEC_D;
         "i":     res.spec_index = SPEC_I;
         "u":     res.spec_index = SPEC_U;
         "x":     res.spec_index = SPEC_X;
         "X":     res.spec_index = SPEC_UX;
         "b":     res.spec_index = SPEC_B;
         "n":     res.spec_index = SPEC_N;
         "a":     res.spec_index = SPEC_A;
         "m":     res.spec_index = SPEC_M;
         default: begin
            res.spec_found = 1'b0;
            res.spec_index = SPEC_C;
         end
      endcase
      if (res.spec_found) begin
         count_char();
      end
      res.flag_bits       = spec_flags;
      res.width_value     = spec_width;
      res.width_given     = spec_width_seen;
      res.precision_value = spec_prec;
      res.precision_given = spec_prec_seen;
      res.chars_used      = spec_count;
      pending_specs.push_back(res);
      clear_spec();
   endfunction

   // After the width, or in place of one, a dot opens the precision; any other character ends the spec.
   function automatic void open_prec_or_end(input logic [7:0] ch);
      if (ch == CH_DOT) begin
         spec_prec_seen = 1'b1;
         spec_prec      = '0;
         count_char();
         spec_phase = PH_PSTART;
      end else begin
         end_spec(ch);
      end
   endfunction

   // Advances the model by one accepted request.
   function automatic void parse_char(input logic [7:0] ch, input logic [31:0] star);
      logic [5:0] flag_bit;
      case (ch)
         CH_DASH:   flag_bit = 6'b000001;
         CH_PLUS:   flag_bit = 6'b000010;
         CH_SPACE:  flag_bit = 6'b000100;
         CH_HASH:   flag_bit = 6'b001000;
         CH_ZERO:   flag_bit = 6'b010000;
         CH_BSLASH: flag_bit = 6'b100000;
         default:   flag_bit = 6'b000000;
      endcase
      case (spec_phase)
         PH_FLAGS: begin
            // A zero here is the zero flag, so a digit width starts at 1 to 9.
            if (flag_bit != 0) begin
               spec_flags = spec_flags | flag_bit;
               count_char();
            end else if (ch == CH_STAR) begin
               spec_width      = star;
               spec_width_seen = 1'b1;
               count_char();
               spec_phase = PH_AFTERW;
            end else if (is_digit(ch)) begin
               spec_width      = 32'(ch - CH_ZERO);
               spec_width_seen = 1'b1;
               count_char();
               spec_phase = PH_WDIG;
            end else begin
               open_prec_or_end(ch);
            end
         end
         PH_WDIG: begin
            if (is_digit(ch)) begin
               spec_width = append_digit(spec_width, ch);
               count_char();
            end else begin
               open_prec_or_end(ch);
            end
         end
         PH_AFTERW: open_prec_or_end(ch);
         PH_PSTART: begin
            // A bare dot leaves the precision at zero.
            if (ch == CH_STAR) begin
               spec_prec = star;
               count_char();
               spec_phase = PH_SPEC;
            end else if (is_digit(ch)) begin
               spec_prec = 32'(ch - CH_ZERO);
               count_char();
               spec_phase = PH_PDIG;
            end else begin
               end_spec(ch);
            end
         end
         PH_PDIG: begin
            if (is_digit(ch)) begin
               spec_prec = append_digit(spec_prec, ch);
               count_char();
            end else begin
               end_spec(ch);
            end
         end
         default: end_spec(ch);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offers one request and returns at the falling edge after it was taken.
   // The valid stays high on return, so back-to-back requests need no dip;
   // whoever stops sending lowers it through wait_for_results.
   task automatic send_char(input logic [7:0] ch, input logic [31:0] star);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 12);
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {star, ch};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      parse_char(ch, star);
      sent_count++;
      @(negedge clock);
   endtask

   // Sends each character of a string with a random argument value.
   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_char(text[i], $urandom());
      end
   endtask

   // Stops offering requests and waits until every owed result has arrived, reporting any that
   // never do, then idles further so that a stray extra result would be seen.
   task automatic wait_for_results();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_specs.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      if (pending_specs.size() != 0) begin
         $error("%0d expected results never arrived", pending_specs.size());
         error_count++;
         pending_specs.delete();
      end
      repeat (4) @(negedge clock);
   endtask

   // Appends a run of decimal digits; long runs can push the value into saturation.
   task automatic add_digits(ref logic [7:0] text[$], input bit lead_nonzero);
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
         if (i == 0 && lead_nonzero) begin
            text.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
         end else begin
            text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
         end
      end
   endtask

   // Builds one random spec and sends it. Most are well formed with random
   // flags, width, precision and specifier; some end on a NUL or a random byte, and a
   // few are plain noise.
   task automatic send_random_spec();
      logic [7:0] text[$];
      int         n;
      int         shape;
      shape = $urandom_range(0, 99);
      if (shape < 10) begin
         n = $urandom_range(1, 4);
         repeat (n) text.push_back(8'($urandom()));
      end else begin
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
         repeat (n) text.push_back(FLAG_SET[$urandom_range(0, 5)]);
         case ($urandom_range(0, 3))
            1: add_digits(text, 1'b1);
            2: text.push_back(CH_STAR);
            default: ;
         endcase
         case ($urandom_range(0, 4))
            1: text.push_back(CH_DOT);
            2: begin
               text.push_back(CH_DOT);
               add_digits(text, 1'b0);
            end
            3: begin
               text.push_back(CH_DOT);
               text.push_back(CH_STAR);
            end
            default: ;
         endcase
         if (shape < 85) begin
            text.push_back(LETTER_SET[$urandom_range(0, 11)]);
         end else if (shape < 90) begin
            text.push_back(8'h00);
         end else begin
            text.push_back(8'($urandom()));
         end
      end
      foreach (text[i]) begin
         // Star arguments are mostly full-range, sometimes small and signed.
         if ($urandom_range(0, 3) == 0) begin
            send_char(text[i], 32'($signed($urandom_range(0, 40)) - 20));
         end else begin
            send_char(text[i], $urandom());
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every flag, every specifier letter, star arguments at both extremes, a
   // bare dot, a zero flag ahead of a width, and invalid ends on NUL and 0xFF.
   task automatic test_directed_specs();
      send_text("-c");
      send_text("+s");
      send_text(" p");
      send_text("#d");
      send_text("0i");
      send_text("\\u");
      send_text("x");
      send_text("X");
      send_text("b");
      send_text("n");
      send_char(CH_STAR, 32'h8000_0000);
      send_text("a");
      send_text(".");
      send_char(CH_STAR, 32'h7FFF_FFFF);
      send_text("m");
      send_text(".d");
      send_text("05");
      send_char(8'h00, 32'hFFFF_FFFF);
      send_char(8'hFF, 32'h0000_0000);
      wait_for_results();
   endtask

   // Specs long enough to saturate the character count, digit runs that
   // saturate width and precision, zeros inside digit runs, and invalid ends
   // in the precision and specifier-only phases.
   task automatic test_long_specs();
      repeat (250) send_char(FLAG_SET[$urandom_range(0, 5)], $urandom());
      send_text("1000000000000.000123456789099d");
      send_text("7.99999999999x");
      send_text("30.12q");
      send_text(".*");
      send_char(8'h80, $urandom());
      send_text("*.");
      send_char(8'h7F, $urandom());
      wait_for_results();
   endtask

   // The bulk of the run. Idling switches on and off in stretches, the sender
   // once drains the block halfway through, and the last part runs flat out.
   task automatic test_random_specs();
      int  first;
      int  next_switch;
      bit  drained;
      first       = sent_count;
      next_switch = sent_count + 50;
      drained     = 1'b0;
      while (sent_count - first < 400) begin
         if (sent_count - first >= 350) begin
            idling_on = 1'b0;
         end else if (sent_count >= next_switch) begin
            idling_on   = ($urandom_range(0, 3) != 0);
            next_switch = next_switch + 50;
         end
         if (!drained && sent_count - first >= 200) begin
            wait_for_results();
            drained = 1'b1;
         end
         send_random_spec();
      end
      wait_for_results();
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   // The receiver stalls in random bursts while idling is on.
   always @(negedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left = rsp_stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(1, 12) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Every result taken off the bus is checked against the oldest owed result.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_specs.size() == 0) begin
            $error("result arrived with none expected");
            error_count++;
         end else begin
            want = pending_specs.pop_front();
            compare_field("spec_found", want.spec_found, rsp_tuser[0]);
            compare_field("spec_index", want.spec_index, rsp_tdata[3:0]);
            compare_field("flag_bits", want.flag_bits, rsp_tdata[9:4]);
            compare_field("width_value", want.width_value, $signed(rsp_tdata[41:10]));
            compare_field("width_given", want.width_given, rsp_tdata[42]);
            compare_field("precision_value", want.precision_value,
                          $signed(rsp_tdata[74:43]));
            compare_field("precision_given", want.precision_given, rsp_tdata[75]);
            compare_field("chars_used", want.chars_used, rsp_tdata[83:76]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Run
   // ---------------------------------------------------------------------

   initial begin
      clear_spec();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_specs();
      test_long_specs();
      test_random_specs();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // A correct run takes well under a tenth of this.
   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/fsp_pkg.sv
src/fsp_in_stage.sv
src/fsp_parse_core.sv
src/fsp_out_stage.sv
src/format_spec_parser.sv
src/fsp_checker.sv
tb/tb_top.sv
